// ----- sv/gacq_pkg.sv -----
// shared types, constants and control store for the ancestor closure query core
`default_nettype none

package gacq_pkg;

    localparam int GACQ_MAX_NODES = 64;
    localparam int CMD_W          = 2;
    localparam int NODE_W         = 6;
    localparam int CNT_W          = 7;
    localparam int CMP_W          = 10;
    localparam int STEP_W         = 4;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 8;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_ARC     = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_RANGE        = 2'd1,
        ST_NOT_COMPUTED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CND_NEXT      = 3'd0,
        CND_ALWAYS    = 3'd1,
        CND_DISPATCH  = 3'd2,
        CND_BAD_ARC   = 3'd3,
        CND_BAD_QUERY = 3'd4,
        CND_V_MORE    = 3'd5,
        CND_K_MORE    = 3'd6,
        CND_CNT_ZERO  = 3'd7
    } cond_t;

    localparam logic [STEP_W-1:0] S_IDLE      = 4'd0;
    localparam logic [STEP_W-1:0] S_CLR       = 4'd1;
    localparam logic [STEP_W-1:0] S_ARC_RD    = 4'd2;
    localparam logic [STEP_W-1:0] S_ARC_WR    = 4'd3;
    localparam logic [STEP_W-1:0] S_QRY_RD    = 4'd4;
    localparam logic [STEP_W-1:0] S_QRY_OUT   = 4'd5;
    localparam logic [STEP_W-1:0] S_ERR       = 4'd6;
    localparam logic [STEP_W-1:0] S_CMP_INIT  = 4'd7;
    localparam logic [STEP_W-1:0] S_CPY_RD    = 4'd8;
    localparam logic [STEP_W-1:0] S_CPY_WR    = 4'd9;
    localparam logic [STEP_W-1:0] S_PIV_START = 4'd10;
    localparam logic [STEP_W-1:0] S_PIV_RD    = 4'd11;
    localparam logic [STEP_W-1:0] S_PIV_WR    = 4'd12;
    localparam logic [STEP_W-1:0] S_PIV_NEXT  = 4'd13;
    localparam logic [STEP_W-1:0] S_CMP_DONE  = 4'd14;

    typedef struct packed {
        logic              accept;
        logic              emit;
        logic              emit_chk;
        logic              emit_found;
        logic              pred_rd;
        logic              pred_wr;
        logic              pred_clr;
        logic              pred_sel_v;
        logic              anc_rd;
        logic              anc_wr;
        logic              anc_sel_q;
        logic              anc_merge;
        logic              v_clr;
        logic              v_inc;
        logic              k_clr;
        logic              k_inc;
        logic              cv_set;
        logic              cv_clr;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    // control store: one word per step
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c        = '0;
        c.cond   = CND_NEXT;
        c.target = S_IDLE;
        case (step)
            S_IDLE: begin
                c.accept = 1'b1;
                c.cond   = CND_DISPATCH;
            end
            S_CLR: begin
                c.emit     = 1'b1;
                c.pred_clr = 1'b1;
                c.cv_clr   = 1'b1;
                c.cond     = CND_ALWAYS;
            end
            S_ARC_RD: begin
                c.pred_rd = 1'b1;
                c.cond    = CND_BAD_ARC;
                c.target  = S_ERR;
            end
            S_ARC_WR: begin
                c.pred_wr = 1'b1;
                c.cv_clr  = 1'b1;
                c.emit    = 1'b1;
                c.cond    = CND_ALWAYS;
            end
            S_QRY_RD: begin
                c.anc_rd    = 1'b1;
                c.anc_sel_q = 1'b1;
                c.cond      = CND_BAD_QUERY;
                c.target    = S_ERR;
            end
            S_QRY_OUT: begin
                c.emit       = 1'b1;
                c.emit_found = 1'b1;
                c.cond       = CND_ALWAYS;
            end
            S_ERR: begin
                c.emit     = 1'b1;
                c.emit_chk = 1'b1;
                c.cond     = CND_ALWAYS;
            end
            S_CMP_INIT: begin
                c.v_clr  = 1'b1;
                c.k_clr  = 1'b1;
                c.cond   = CND_CNT_ZERO;
                c.target = S_CMP_DONE;
            end
            S_CPY_RD: begin
                c.pred_rd    = 1'b1;
                c.pred_sel_v = 1'b1;
            end
            S_CPY_WR: begin
                c.pred_sel_v = 1'b1;
                c.anc_wr     = 1'b1;
                c.v_inc      = 1'b1;
                c.cond       = CND_V_MORE;
                c.target     = S_CPY_RD;
            end
            S_PIV_START: begin
                c.v_clr = 1'b1;
            end
            S_PIV_RD: begin
                c.anc_rd = 1'b1;
            end
            S_PIV_WR: begin
                c.anc_wr    = 1'b1;
                c.anc_merge = 1'b1;
                c.v_inc     = 1'b1;
                c.cond      = CND_V_MORE;
                c.target    = S_PIV_RD;
            end
            S_PIV_NEXT: begin
                c.k_inc  = 1'b1;
                c.cond   = CND_K_MORE;
                c.target = S_PIV_START;
            end
            S_CMP_DONE: begin
                c.cv_set = 1'b1;
                c.emit   = 1'b1;
                c.cond   = CND_ALWAYS;
            end
            default: begin
                c.cond = CND_ALWAYS;
            end
        endcase
        return c;
    endfunction

    function automatic logic [STEP_W-1:0] dispatch(input logic [CMD_W-1:0] cmd);
        logic [STEP_W-1:0] s;
        case (cmd)
            CMD_CLEAR:   s = S_CLR;
            CMD_ARC:     s = S_ARC_RD;
            CMD_COMPUTE: s = S_CMP_INIT;
            CMD_QUERY:   s = S_QRY_RD;
            default:     s = S_IDLE;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- sv/graph_ancestor_closure_query_core.sv -----
// clear runs S_CLR; arc S_ARC_RD, S_ARC_WR; query S_QRY_RD, S_QRY_OUT; range or not-computed
// errors go from the read step to S_ERR; compute: copy pass, a pivot pass per node, S_CMP_DONE
// one item in flight; control store steps once per cycle unless held; ancestor ram has 2 reads
// reset: empty graph (per-row valid flops cleared), node_count 64, closure not valid
// no clearing pass after reset; the input is ready on the first cycle after reset
`default_nettype none

module graph_ancestor_closure_query_core
    import gacq_pkg::*;
#(
    parameter int MAX_NODES = GACQ_MAX_NODES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // s_tdata: command[1:0], node_a[7:2], node_b[13:8], zero[15:14]
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata: common_found[0], status[2:1], zero[7:3]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CNT_W-1:0]     cfg_data
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    ctrl_t                 cw;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [NODE_W-1:0]     a_reg, b_reg;
    logic [CMP_W-1:0]      v_reg, k_reg;
    logic [CNT_W-1:0]      node_count_reg;
    logic                  cv_reg;
    logic [MAX_NODES-1:0]  pred_vld_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [CMP_W-1:0]      cnt, a_ext, b_ext;
    logic                  hold, adv, cond_true, range_bad, s_xfer;
    logic [MAX_NODES-1:0]  col_mask, onehot_a, onehot_v;
    logic [MAX_NODES-1:0]  pred_q, anc_qa, anc_qb, pred_wdata, anc_wdata, pred_row;
    logic [AW-1:0]         pred_raddr, anc_raddr_a, anc_raddr_b, v_addr, b_addr;
    logic                  found;
    status_t               status;

    assign cw        = ucode(step_reg);
    assign s_tready  = cw.accept;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign cnt   = ({{(CMP_W-CNT_W){1'b0}}, node_count_reg} < CMP_W'(MAX_NODES)) ?
                   {{(CMP_W-CNT_W){1'b0}}, node_count_reg} : CMP_W'(MAX_NODES);
    assign a_ext = {{(CMP_W-NODE_W){1'b0}}, a_reg};
    assign b_ext = {{(CMP_W-NODE_W){1'b0}}, b_reg};
    assign range_bad = (a_ext >= cnt) || (b_ext >= cnt);

    assign v_addr = v_reg[AW-1:0];
    assign b_addr = b_ext[AW-1:0];

    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            col_mask[i] = CMP_W'(i) < cnt;
            onehot_a[i] = CMP_W'(i) == a_ext;
            onehot_v[i] = CMP_W'(i) == v_reg;
        end
    end

    // stall while idle with no input, or where a result must go out and the output register is still full
    assign hold = (cw.accept && !s_tvalid) || (cw.emit && m_tvalid_reg && !m_tready);
    assign adv  = !hold;

    always_comb begin
        case (cw.cond)
            CND_NEXT:      cond_true = 1'b0;
            CND_ALWAYS:    cond_true = 1'b1;
            CND_DISPATCH:  cond_true = 1'b1;
            CND_BAD_ARC:   cond_true = range_bad;
            CND_BAD_QUERY: cond_true = range_bad || !cv_reg;
            CND_V_MORE:    cond_true = (v_reg + CMP_W'(1)) < cnt;
            CND_K_MORE:    cond_true = (k_reg + CMP_W'(1)) < cnt;
            CND_CNT_ZERO:  cond_true = cnt == '0;
            default:       cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (hold) begin
            step_next = step_reg;
        end else if (cw.cond == CND_DISPATCH) begin
            step_next = dispatch(s_tdata[CMD_W-1:0]);
        end else if (cond_true) begin
            step_next = cw.target;
        end else begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    // predecessor row as stored, with rows not written since reset or the last clear reading as zero
    assign pred_row   = pred_vld_reg[pred_raddr] ? pred_q : '0;
    assign pred_raddr = cw.pred_sel_v ? v_addr : b_addr;
    assign pred_wdata = pred_row | onehot_a;

    // copy pass seeds reflexive rows; pivot pass ors row k into rows holding bit k
    assign anc_raddr_a = cw.anc_sel_q ? a_ext[AW-1:0] : k_reg[AW-1:0];
    assign anc_raddr_b = cw.anc_sel_q ? b_addr : v_addr;
    assign anc_wdata   = cw.anc_merge ?
                         (anc_qb | (anc_qb[k_reg[AW-1:0]] ? anc_qa : '0)) :
                         ((pred_row & col_mask) | onehot_v);

    assign found  = cw.emit_found && ((anc_qa & anc_qb) != '0);
    assign status = cw.emit_chk ? (range_bad ? ST_RANGE : ST_NOT_COMPUTED) : ST_OK;

    logic [AW-1:0] pred_raddr_hold;
    assign pred_raddr_hold = pred_raddr;

    gacq_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_pred_ram (
        .aclk    (aclk),
        .we      (cw.pred_wr && adv),
        .waddr   (b_addr),
        .wdata   (pred_wdata),
        .re_a    (cw.pred_rd && adv),
        .raddr_a (pred_raddr_hold),
        .rdata_a (pred_q),
        .re_b    (1'b0),
        .raddr_b (pred_raddr_hold),
        .rdata_b ()
    );

    gacq_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_anc_ram (
        .aclk    (aclk),
        .we      (cw.anc_wr && adv),
        .waddr   (v_addr),
        .wdata   (anc_wdata),
        .re_a    (cw.anc_rd && adv),
        .raddr_a (anc_raddr_a),
        .rdata_a (anc_qa),
        .re_b    (cw.anc_rd && adv),
        .raddr_b (anc_raddr_b),
        .rdata_b (anc_qb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg       <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            node_count_reg <= CNT_W'(64);
            cv_reg         <= 1'b0;
            pred_vld_reg   <= '0;
        end else begin
            step_reg <= step_next;

            if (adv && cw.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready) begin
                node_count_reg <= cfg_data;
            end

            if (cfg_valid && cfg_ready) begin
                cv_reg <= 1'b0;
            end else if (adv && cw.cv_set) begin
                cv_reg <= 1'b1;
            end else if (adv && cw.cv_clr) begin
                cv_reg <= 1'b0;
            end

            if (adv && cw.pred_clr) begin
                pred_vld_reg <= '0;
            end else if (adv && cw.pred_wr) begin
                pred_vld_reg[b_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            a_reg <= s_tdata[CMD_W+NODE_W-1:CMD_W];
            b_reg <= s_tdata[CMD_W+2*NODE_W-1:CMD_W+NODE_W];
        end
        if (adv && cw.v_clr) begin
            v_reg <= '0;
        end else if (adv && cw.v_inc) begin
            v_reg <= v_reg + CMP_W'(1);
        end
        if (adv && cw.k_clr) begin
            k_reg <= '0;
        end else if (adv && cw.k_inc) begin
            k_reg <= k_reg + CMP_W'(1);
        end
        if (adv && cw.emit) begin
            m_tdata_reg <= {{(M_TDATA_W-3){1'b0}}, status, found};
        end
    end

    // ancestor rows are only written for nodes in use
    a_anc_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.anc_wr && adv) |-> (v_reg < cnt))
        else $error("ancestor write beyond node count");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.emit && adv) |-> !(m_tvalid_reg && !m_tready))
        else $error("result register overwritten");

    // common_found only with an ok status
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[2:1] == ST_OK))
        else $error("found flag with error status");

    // status code three is never produced
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:1] != 2'd3))
        else $error("illegal status code");

    // closure becomes valid only at the end of a compute
    a_cv_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(cv_reg) |-> ($past(step_reg) == S_CMP_DONE))
        else $error("closure valid set outside compute");

endmodule

`default_nettype wire

// ----- sv/gacq_ram.sv -----
// generic simple ram: one write port, two read ports with registered data
`default_nettype none

module gacq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                    wdata,
    input  wire logic                                re_a,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    output logic      [WIDTH-1:0]                    rdata_a,
    input  wire logic                                re_b,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic      [WIDTH-1:0]                    rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re_a) begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b) begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire
